// File: hw/rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers included by iaid_seq
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// boolean that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/iaid_pkg.sv
// -----------------------------------------------------------------------------
// iaid_pkg
// shared types and constants of the indexed list store
// -----------------------------------------------------------------------------
package iaid_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int CMD_W    = 2;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;

   // memory port control
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // one finished result
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic [COUNT_W-1:0]  entry_count;
   } result_type;

endpackage

// File: hw/rtl/iaid_mem.sv
// -----------------------------------------------------------------------------
// iaid_mem
// entry storage, one write and one registered read per cycle
// -----------------------------------------------------------------------------
module iaid_mem #(
   parameter int CAPACITY   = iaid_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = iaid_pkg::DATA_WIDTH_DEF,
   localparam int AW        = $clog2(CAPACITY)
) (
   input  logic                  clock,
   input  iaid_pkg::mem_ctl_type mem_ctl,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/iaid_seq.sv
// -----------------------------------------------------------------------------
// iaid_seq
// command sequencer with a shared cursor step unit for entry moves
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module iaid_seq #(
   parameter int CAPACITY   = iaid_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = iaid_pkg::DATA_WIDTH_DEF,
   localparam int AW        = $clog2(CAPACITY)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [iaid_pkg::CMD_W-1:0]    req_command,
   input  logic [iaid_pkg::POS_W-1:0]    req_position,
   input  logic [iaid_pkg::VALUE_W-1:0]  req_value_in,
   output iaid_pkg::mem_ctl_type         mem_ctl,
   output logic [AW-1:0]                 wr_addr,
   output logic [DATA_WIDTH-1:0]         wr_data,
   output logic [AW-1:0]                 rd_addr,
   input  logic [DATA_WIDTH-1:0]         rd_data,
   output logic                          res_valid,
   input  logic                          res_ready,
   output iaid_pkg::result_type          res
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > iaid_pkg::POS_W) ? CNT_W : iaid_pkg::POS_W;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RD    = 7'b0000010,
      S_WR    = 7'b0000100,
      S_PUT   = 7'b0001000,
      S_FETCH = 7'b0010000,
      S_LATCH = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [AW-1:0]                    cur_ff, cur_in;
   logic [AW-1:0]                    limit_ff, limit_in;
   logic                             down_ff, down_in;
   logic [DATA_WIDTH-1:0]            value_ff, value_in;
   logic [iaid_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [iaid_pkg::VALUE_W-1:0]     rdval_ff, rdval_in;

   logic [CMP_W-1:0] pos_x, cnt_x, slot_x;
   logic [AW-1:0]    cur_next;
   logic             accept;

   assign pos_x  = CMP_W'(req_position);
   assign cnt_x  = CMP_W'(count_ff);
   assign slot_x = (pos_x > cnt_x) ? cnt_x : pos_x;
   assign accept = req_valid && req_ready;

   // shared step unit: next cursor is both the move read address and the cursor update
   assign cur_next = down_ff ? (cur_ff - AW'(1)) : (cur_ff + AW'(1));

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      mem_ctl.wr_en = (state_ff == S_WR) || (state_ff == S_PUT);
      mem_ctl.rd_en = (state_ff == S_RD) || (state_ff == S_FETCH);
   end
   assign wr_addr = cur_ff;
   assign wr_data = (state_ff == S_PUT) ? value_ff : rd_data;
   assign rd_addr = (state_ff == S_FETCH) ? cur_ff : cur_next;

   assign res_valid       = (state_ff == S_DONE);
   assign res.status      = status_ff;
   assign res.read_value  = rdval_ff;
   assign res.entry_count = iaid_pkg::COUNT_W'(count_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      limit_in  = limit_ff;
      down_in   = down_ff;
      value_in  = value_ff;
      status_in = status_ff;
      rdval_in  = rdval_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = iaid_pkg::ST_DONE;
               rdval_in  = '0;
               value_in  = DATA_WIDTH'($unsigned(req_value_in));
               unique case (iaid_pkg::cmd_type'(req_command))
                  iaid_pkg::CMD_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = iaid_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                        cur_in   = AW'(cnt_x);
                        limit_in = AW'(slot_x);
                        down_in  = 1'b1;
                        state_in = (cnt_x != slot_x) ? S_RD : S_PUT;
                     end
                  end
                  iaid_pkg::CMD_REMOVE: begin
                     if (pos_x == '0 || pos_x > cnt_x) begin
                        status_in = iaid_pkg::ST_BADPOS;
                        state_in  = S_DONE;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        cur_in   = AW'(pos_x - CMP_W'(1));
                        limit_in = AW'(cnt_x - CMP_W'(1));
                        down_in  = 1'b0;
                        state_in = (pos_x != cnt_x) ? S_RD : S_DONE;
                     end
                  end
                  iaid_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  iaid_pkg::CMD_READ: begin
                     if (pos_x >= cnt_x) begin
                        status_in = iaid_pkg::ST_BADPOS;
                        state_in  = S_DONE;
                     end else begin
                        cur_in   = AW'(pos_x);
                        state_in = S_FETCH;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_RD: state_in = S_WR;
         S_WR: begin
            cur_in = cur_next;
            if (cur_next != limit_ff) begin
               state_in = S_RD;
            end else begin
               state_in = down_ff ? S_PUT : S_DONE;
            end
         end
         S_PUT:   state_in = S_DONE;
         S_FETCH: state_in = S_LATCH;
         S_LATCH: begin
            rdval_in = iaid_pkg::VALUE_W'(rd_data);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      limit_ff  <= limit_in;
      down_ff   <= down_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
   end

   `ASSERT_ALWAYS(a_count_cap, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `ASSERT_IMPLY(a_ins_cursor, clock, reset, state_ff == S_RD && down_ff, cur_ff > limit_ff)
   `ASSERT_IMPLY(a_rem_cursor, clock, reset, state_ff == S_RD && !down_ff, cur_ff < limit_ff)
   `ASSERT_NEXT(a_res_hold, clock, reset, res_valid && !res_ready, res_valid && $stable(res))

endmodule

// File: hw/rtl/indexed_array_insert_delete_top.sv
// -----------------------------------------------------------------------------
// indexed_array_insert_delete_top
// fixed capacity ordered list store with insert, remove, clear and read
// -----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  req     | req_valid/ready, command, position, value_in | in
//  rsp     | rsp_valid/ready, status, read_value, count   | out
//
//  an entry move reads an entry and then writes it one slot over; insert
//  moves the entries from the slot on up by one and then writes the value,
//  remove moves those after the slot down by one, and read fetches one entry
//  one request in flight; a finished result waits in the rsp register while
//  the next request is taken
//  synchronous active high reset clears the count and the control; the
//  entry memory has no reset and is never read above the count
// -----------------------------------------------------------------------------
module indexed_array_insert_delete_top #(
   parameter int CAPACITY   = iaid_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = iaid_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [iaid_pkg::CMD_W-1:0]          req_command,
   input  logic [iaid_pkg::POS_W-1:0]          req_position,
   input  logic signed [iaid_pkg::VALUE_W-1:0] req_value_in,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [iaid_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [iaid_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [iaid_pkg::COUNT_W-1:0]        rsp_entry_count
);

   localparam int AW = $clog2(CAPACITY);

   iaid_pkg::mem_ctl_type  mem_ctl;
   logic [AW-1:0]          wr_addr;
   logic [DATA_WIDTH-1:0]  wr_data;
   logic [AW-1:0]          rd_addr;
   logic [DATA_WIDTH-1:0]  rd_data;
   logic                   res_valid;
   logic                   res_ready;
   iaid_pkg::result_type   res;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   iaid_pkg::result_type   rsp_ff, rsp_in;

   // sequencer: decodes the request and walks the cursor over the entries
   iaid_seq #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_position (req_position),
      .req_value_in (req_value_in),
      .mem_ctl      (mem_ctl),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res)
   );

   // entry memory
   iaid_mem #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result moves in when the register is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_entry_count = rsp_ff.entry_count;

endmodule
